// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the design checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== design/mqttpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mqttpq_pkg
// Types, codes and reset values of the MQTT publish QoS handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mqttpq_pkg;

    localparam int unsigned IDENT_W = 16;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned LIMIT_W = 4;
    localparam int unsigned CFG_W   = 16;

    localparam logic [COUNT_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 4'd3;

    typedef enum logic [0:0] {
        REG_TIMEOUT = 1'b0,
        REG_RETRY   = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_TXDONE = 2'd2,
        ACT_PACKET = 2'd3
    } action_t;

    localparam logic [3:0] KIND_PUBACK  = 4'd4;
    localparam logic [3:0] KIND_PUBREC  = 4'd5;
    localparam logic [3:0] KIND_PUBCOMP = 4'd7;

    localparam logic [1:0] QOS_0       = 2'd0;
    localparam logic [1:0] QOS_1       = 2'd1;
    localparam logic [1:0] QOS_INVALID = 2'd3;

    typedef enum logic [2:0] {
        EV_REFUSED  = 3'd0,
        EV_ACCEPTED = 3'd1,
        EV_PUBLISH  = 3'd2,
        EV_PUBREL   = 3'd3,
        EV_DONE     = 3'd4,
        EV_TIMEOUT  = 3'd5
    } event_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_ARMED     = 3'd1,
        PH_Q0_TX     = 3'd2,
        PH_WAIT_ACK  = 3'd3,
        PH_WAIT_REC  = 3'd4,
        PH_WAIT_COMP = 3'd5
    } phase_t;

    typedef struct packed {
        logic [COUNT_W-1:0] reply_timeout_ticks;
        logic [LIMIT_W-1:0] retry_limit;
    } cfg_t;

    typedef struct packed {
        action_t            action;
        logic               link_up;
        logic [1:0]         qos_level;
        logic               retain_req;
        logic [3:0]         packet_kind;
        logic [IDENT_W-1:0] packet_ident;
    } item_t;

    typedef struct packed {
        phase_t             phase;
        logic [LIMIT_W-1:0] attempt_count;
        logic [COUNT_W-1:0] countdown;
        logic [IDENT_W-1:0] current_ident;
        logic [IDENT_W-1:0] ident_counter;
        logic [1:0]         held_qos;
        logic               held_retain;
    } state_t;

    typedef struct packed {
        logic               fire;
        event_t             event_res;
        logic [1:0]         qos_bits;
        logic               retain_bit;
        logic               dup_bit;
        logic [IDENT_W-1:0] ident_out;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase:         PH_IDLE,
        attempt_count: '0,
        countdown:     '0,
        current_ident: '0,
        ident_counter: 16'd1,
        held_qos:      '0,
        held_retain:   1'b0
    };

endpackage

// ===== design/mqttpq_step.sv =====
// ----------------------------------------------------------------------------
// mqttpq_step
// Next-state and result logic for one event of the publish handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqttpq_step
(
    input  mqttpq_pkg::state_t  cur,
    input  mqttpq_pkg::cfg_t    cfg,
    input  mqttpq_pkg::item_t   item,
    output mqttpq_pkg::state_t  nxt,
    output mqttpq_pkg::result_t res
);

    logic                               fail;
    logic                               send;
    logic                               kind_match;
    logic                               ident_match;
    logic [mqttpq_pkg::IDENT_W-1:0]     ident_inc;
    logic [mqttpq_pkg::LIMIT_W:0]       attempt_inc;

    assign ident_inc   = cur.ident_counter + 16'd1;
    assign attempt_inc = {1'b0, cur.attempt_count} + 5'd1;
    assign ident_match = (item.packet_ident == cur.current_ident);
    assign kind_match  =
        ((cur.phase == mqttpq_pkg::PH_WAIT_ACK)  && (item.packet_kind == mqttpq_pkg::KIND_PUBACK))
     || ((cur.phase == mqttpq_pkg::PH_WAIT_REC)  && (item.packet_kind == mqttpq_pkg::KIND_PUBREC))
     || ((cur.phase == mqttpq_pkg::PH_WAIT_COMP) && (item.packet_kind == mqttpq_pkg::KIND_PUBCOMP));

    always_comb
    begin
        nxt  = cur;
        res  = '0;
        fail = 1'b0;
        send = 1'b0;

        unique case (item.action)
            mqttpq_pkg::ACT_START:
            begin
                res.fire = 1'b1;
                if (!item.link_up || (cur.phase != mqttpq_pkg::PH_IDLE))
                begin
                    res.event_res = mqttpq_pkg::EV_REFUSED;
                end
                else
                begin
                    nxt.ident_counter = (ident_inc == '0) ? 16'd1 : ident_inc;
                    nxt.current_ident = nxt.ident_counter;
                    nxt.held_qos      = item.qos_level;
                    nxt.held_retain   = item.retain_req;
                    nxt.attempt_count = '0;
                    nxt.phase         = mqttpq_pkg::PH_ARMED;
                    res.event_res     = mqttpq_pkg::EV_ACCEPTED;
                    res.qos_bits      = item.qos_level;
                    res.retain_bit    = item.retain_req;
                    res.ident_out     = nxt.ident_counter;
                end
            end
            mqttpq_pkg::ACT_TICK:
            begin
                if (cur.phase == mqttpq_pkg::PH_ARMED)
                begin
                    nxt.attempt_count = '0;
                    if (cur.held_qos == mqttpq_pkg::QOS_0)
                    begin
                        nxt.phase      = mqttpq_pkg::PH_Q0_TX;
                        res.fire       = 1'b1;
                        res.event_res  = mqttpq_pkg::EV_PUBLISH;
                        res.retain_bit = cur.held_retain;
                        res.ident_out  = cur.current_ident;
                    end
                    else if (cur.held_qos == mqttpq_pkg::QOS_INVALID)
                    begin
                        nxt.phase = mqttpq_pkg::PH_IDLE;
                    end
                    else
                    begin
                        nxt.phase = (cur.held_qos == mqttpq_pkg::QOS_1)
                                  ? mqttpq_pkg::PH_WAIT_ACK : mqttpq_pkg::PH_WAIT_REC;
                        send = 1'b1;
                    end
                end
                else if ((cur.phase == mqttpq_pkg::PH_WAIT_ACK)
                      || (cur.phase == mqttpq_pkg::PH_WAIT_REC)
                      || (cur.phase == mqttpq_pkg::PH_WAIT_COMP))
                begin
                    if (cur.countdown > 16'd1)
                    begin
                        nxt.countdown = cur.countdown - 16'd1;
                    end
                    else
                    begin
                        nxt.countdown = '0;
                        fail          = 1'b1;
                    end
                end
            end
            mqttpq_pkg::ACT_TXDONE:
            begin
                if (cur.phase == mqttpq_pkg::PH_Q0_TX)
                begin
                    nxt.phase     = mqttpq_pkg::PH_IDLE;
                    res.fire      = 1'b1;
                    res.event_res = mqttpq_pkg::EV_DONE;
                    res.ident_out = cur.current_ident;
                end
            end
            mqttpq_pkg::ACT_PACKET:
            begin
                if (kind_match)
                begin
                    if (!ident_match)
                    begin
                        fail = 1'b1;
                    end
                    else if (cur.phase == mqttpq_pkg::PH_WAIT_REC)
                    begin
                        nxt.phase         = mqttpq_pkg::PH_WAIT_COMP;
                        nxt.attempt_count = '0;
                        send              = 1'b1;
                    end
                    else
                    begin
                        nxt.phase         = mqttpq_pkg::PH_IDLE;
                        nxt.attempt_count = '0;
                        res.fire          = 1'b1;
                        res.event_res     = mqttpq_pkg::EV_DONE;
                        res.ident_out     = cur.current_ident;
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase

        if (fail)
        begin
            if (attempt_inc >= {1'b0, cfg.retry_limit})
            begin
                nxt.phase         = mqttpq_pkg::PH_IDLE;
                nxt.attempt_count = '0;
                res.fire          = 1'b1;
                res.event_res     = mqttpq_pkg::EV_TIMEOUT;
                res.ident_out     = cur.current_ident;
            end
            else
            begin
                nxt.attempt_count = attempt_inc[mqttpq_pkg::LIMIT_W-1:0];
                send              = 1'b1;
            end
        end

        if (send)
        begin
            nxt.countdown = cfg.reply_timeout_ticks;
            res.fire      = 1'b1;
            res.ident_out = cur.current_ident;
            if (nxt.phase == mqttpq_pkg::PH_WAIT_COMP)
            begin
                res.event_res = mqttpq_pkg::EV_PUBREL;
            end
            else
            begin
                res.event_res  = mqttpq_pkg::EV_PUBLISH;
                res.qos_bits   = cur.held_qos;
                res.retain_bit = cur.held_retain;
                res.dup_bit    = (nxt.attempt_count != '0);
            end
        end
    end

endmodule

// ===== design/mqtt_publish_qos_handshake.sv =====
// ----------------------------------------------------------------------------
// mqtt_publish_qos_handshake
// Publisher side of the MQTT QoS 0/1/2 publish handshake.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event per beat: start,
//   tick, transmit done or packet received, with its fields. Output channel
//   (out_valid / out_stall) carries at most one result beat per event:
//   refused, accepted, send PUBLISH, send PUBREL, done or timed out.
//   Events that cause no result are consumed silently.
//   Configuration (cfg_we / cfg_index / cfg_data) sets the reply timeout
//   and the retry limit; write it only while no event is in flight.
//   An accepted event is held in the input register and is then processed;
//   its result is valid right after that update. One event per cycle while
//   out_stall holds no result, set by the single input and result registers.
//   Reset clears the handshake to idle, the message id counter to one, the
//   timeout to 1000 ticks and the retry limit to 3.
//   While out_stall is high and a result is held, the input register holds
//   its event and in_stall rises once that register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqtt_publish_qos_handshake
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic        link_up,
    input  logic [1:0]  qos_level,
    input  logic        retain_req,
    input  logic [3:0]  packet_kind,
    input  logic [15:0] packet_ident,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic [1:0]  qos_bits,
    output logic        retain_bit,
    output logic        dup_bit,
    output logic [15:0] ident_out
);

    logic                in_valid_reg;
    mqttpq_pkg::item_t   item_reg;
    mqttpq_pkg::state_t  state_reg;
    mqttpq_pkg::state_t  state_next;
    mqttpq_pkg::cfg_t    cfg_reg;
    logic                out_valid_reg;
    mqttpq_pkg::result_t res_reg;
    mqttpq_pkg::result_t res_next;
    logic                advance;
    logic                step_fire;

    assign advance   = !out_valid_reg || !out_stall;
    assign step_fire = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;

    mqttpq_step u_step
    (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reply_timeout_ticks <= mqttpq_pkg::TIMEOUT_RESET;
            cfg_reg.retry_limit         <= mqttpq_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (mqttpq_pkg::reg_index_t'(cfg_index))
                mqttpq_pkg::REG_TIMEOUT: cfg_reg.reply_timeout_ticks <= cfg_data;
                mqttpq_pkg::REG_RETRY:   cfg_reg.retry_limit <= cfg_data[3:0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.action       <= mqttpq_pkg::action_t'(action);
            item_reg.link_up      <= link_up;
            item_reg.qos_level    <= qos_level;
            item_reg.retain_req   <= retain_req;
            item_reg.packet_kind  <= packet_kind;
            item_reg.packet_ident <= packet_ident;
        end
    end

    // handshake state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mqttpq_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (step_fire)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= step_fire && res_next.fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && res_next.fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_res  = res_reg.event_res;
    assign qos_bits   = res_reg.qos_bits;
    assign retain_bit = res_reg.retain_bit;
    assign dup_bit    = res_reg.dup_bit;
    assign ident_out  = res_reg.ident_out;

endmodule

// ===== design/mqttpq_checker.sv =====
// ----------------------------------------------------------------------------
// mqttpq_checker
// Port-level checks of the publish handshake, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mqttpq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  event_res,
    input logic [1:0]  qos_bits,
    input logic        retain_bit,
    input logic        dup_bit,
    input logic [15:0] ident_out
);

    `ASSERT_CLK(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(event_res) && $stable(ident_out)), "result beat changed while stalled")

    `ASSERT_CLK(a_event_range, out_valid |-> (event_res <= mqttpq_pkg::EV_TIMEOUT), "result code out of range")

    `ASSERT_CLK(a_refused_zero, (out_valid && (event_res == mqttpq_pkg::EV_REFUSED)) |-> ((qos_bits == 2'd0) && !retain_bit && !dup_bit && (ident_out == 16'd0)), "refused beat carries nonzero fields")

    `ASSERT_CLK(a_accept_ident, (out_valid && (event_res == mqttpq_pkg::EV_ACCEPTED)) |-> ((ident_out != 16'd0) && !dup_bit), "accepted beat has zero id or dup set")

    `ASSERT_CLK(a_ack_flags, (out_valid && ((event_res == mqttpq_pkg::EV_PUBREL) || (event_res == mqttpq_pkg::EV_DONE) || (event_res == mqttpq_pkg::EV_TIMEOUT))) |-> ((qos_bits == 2'd0) && !retain_bit && !dup_bit && (ident_out != 16'd0)), "non-publish beat carries header flags")

endmodule

bind mqtt_publish_qos_handshake mqttpq_checker u_mqttpq_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_res  (event_res),
    .qos_bits   (qos_bits),
    .retain_bit (retain_bit),
    .dup_bit    (dup_bit),
    .ident_out  (ident_out)
);
